@@ rtl/core/dwb_pkg.sv @@
// Shared types and constants for the dynamic window bounds block.
// Holds the item, queue entry and configuration structs and the register indexes.
// No dependencies.
package dwb_pkg;

	localparam int DATA_W = 32;
	localparam int UVAL_W = 31;
	localparam int PERIOD_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W = UVAL_W + PERIOD_W;

	localparam int SQ_W = 33;
	localparam int PIPE_LATENCY = 2 * SQ_W + 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD = 3'd0,
		CFG_MAX_LIN_VEL = 3'd1,
		CFG_MAX_ANG_VEL = 3'd2,
		CFG_MAX_LIN_ACCEL = 3'd3,
		CFG_MAX_ANG_ACCEL = 3'd4,
		CFG_GOAL_X = 3'd5,
		CFG_GOAL_Y = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ms;
		logic [UVAL_W-1:0] max_linear_velocity;
		logic [UVAL_W-1:0] max_angular_velocity;
		logic [UVAL_W-1:0] max_linear_accel;
		logic [UVAL_W-1:0] max_angular_accel;
		logic signed [DATA_W-1:0] goal_x;
		logic signed [DATA_W-1:0] goal_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		period_ms: 10'd100,
		max_linear_velocity: 31'd32768,
		max_angular_velocity: 31'd65536,
		max_linear_accel: 31'd32768,
		max_angular_accel: 31'd65536,
		goal_x: 32'sd131072,
		goal_y: 32'sd65536
	};

	typedef struct packed {
		logic signed [DATA_W-1:0] forward_velocity;
		logic signed [DATA_W-1:0] turn_rate;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
	} in_item_t;

	typedef struct packed {
		logic [UVAL_W-1:0] lin_low;
		logic [UVAL_W-1:0] lin_high;
		logic signed [DATA_W-1:0] ang_low;
		logic signed [DATA_W-1:0] ang_high;
	} out_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] w;
		logic [DATA_W-1:0] ux;
		logic [DATA_W-1:0] uy;
		logic [PROD_W-1:0] lin_prod;
		logic [PROD_W-1:0] ang_prod;
	} q_item_t;

endpackage

@@ rtl/core/dwb_front.sv @@
// Front end: turns an odometry sample into a queue entry.
// Forms the goal distance components and the acceleration-period products.
// Depends on dwb_pkg.
module dwb_front
	import dwb_pkg::*;
(
	input in_item_t item,
	input cfg_t cfg,
	output q_item_t entry
);

	logic signed [DATA_W:0] dx;
	logic signed [DATA_W:0] dy;

	always_comb begin
		dx = (DATA_W+1)'(item.pos_x) - (DATA_W+1)'(cfg.goal_x);
		dy = (DATA_W+1)'(item.pos_y) - (DATA_W+1)'(cfg.goal_y);
		entry.v = item.forward_velocity;
		entry.w = item.turn_rate;
		entry.ux = dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
		entry.uy = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
		entry.lin_prod = PROD_W'(cfg.max_linear_accel) * PROD_W'(cfg.period_ms);
		entry.ang_prod = PROD_W'(cfg.max_angular_accel) * PROD_W'(cfg.period_ms);
	end

endmodule

@@ rtl/core/dwb_queue.sv @@
// Short FIFO between the front end and the arithmetic back end.
// Register array with read and write pointers and an occupancy count.
// Depends on dwb_pkg.
module dwb_queue
	import dwb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input q_item_t wdata,
	input logic pop,
	output q_item_t rdata,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

@@ rtl/core/dwb_back.sv @@
// Back end: squares, two bit-per-stage square root pipelines and the divide by 1000.
// Clamps the velocity window and applies the braking cap; one result per entry.
// Depends on dwb_pkg.
module dwb_back
	import dwb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input q_item_t in_item,
	input cfg_t cfg,
	output logic done,
	output out_item_t result
);

	localparam int RAD_W = 2 * SQ_W;
	localparam int SQ_REM_W = SQ_W + 2;
	localparam int QUO_W = DATA_W;
	localparam int SUM_W = DATA_W + 2;
	localparam int MUL_W = 2 * DATA_W;

	localparam int DIV_LAT = 3;
	localparam int RCP_SHR = 3;
	localparam int Y_W = PROD_W - RCP_SHR;
	localparam int RCP_SPLIT = 19;
	localparam int RCP_K = 45;
	localparam int RCP_M_W = 39;
	localparam logic [RCP_M_W-1:0] RCP_M = 39'd281474976711;
	localparam int PP_W = 2 * RCP_SPLIT + 1;
	localparam int MID_W = PP_W + 1;
	localparam int ACC_W = PP_W + RCP_SPLIT + 1;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [PP_W-1:0] hh;
		logic [PP_W-1:0] hl;
		logic [PP_W-1:0] lh;
		logic [PP_W-1:0] ll;
	} pp_t;

	typedef struct packed {
		logic [PP_W-1:0] hh;
		logic [MID_W-1:0] mid;
	} pm_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		sq_t sq;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] w;
		logic [QUO_W-1:0] lin_step;
		logic [QUO_W-1:0] ang_step;
	} row1_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		sq_t sq;
		logic [UVAL_W-1:0] v_lo;
		logic signed [DATA_W-1:0] v_hi;
		logic signed [DATA_W-1:0] w_lo;
		logic signed [DATA_W-1:0] w_hi;
	} row2_t;

	function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
		logic [SQ_REM_W+1:0] acc;
		logic [SQ_REM_W+1:0] trial;
		sq_t r;
		acc = {s.rem, pair};
		trial = {{(SQ_REM_W - SQ_W){1'b0}}, s.root, 2'b01};
		if (acc >= trial) begin
			r.rem = SQ_REM_W'(acc - trial);
			r.root = {s.root[SQ_W-2:0], 1'b1};
		end else begin
			r.rem = acc[SQ_REM_W-1:0];
			r.root = {s.root[SQ_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Division by 1000 is a shift by 3 followed by a reciprocal multiply for 125,
	// split into four narrow partial products.
	function automatic pp_t rcp_products(input logic [PROD_W-1:0] x);
		logic [Y_W-1:0] y;
		logic [Y_W-RCP_SPLIT-1:0] yh;
		logic [RCP_SPLIT-1:0] yl;
		pp_t r;
		y = x[PROD_W-1:RCP_SHR];
		yh = y[Y_W-1:RCP_SPLIT];
		yl = y[RCP_SPLIT-1:0];
		r.hh = PP_W'(yh) * PP_W'(RCP_M[RCP_M_W-1:RCP_SPLIT]);
		r.hl = PP_W'(yh) * PP_W'(RCP_M[RCP_SPLIT-1:0]);
		r.lh = PP_W'(yl) * PP_W'(RCP_M[RCP_M_W-1:RCP_SPLIT]);
		r.ll = PP_W'(yl) * PP_W'(RCP_M[RCP_SPLIT-1:0]);
		return r;
	endfunction

	function automatic pm_t rcp_fold(input pp_t p);
		pm_t r;
		r.hh = p.hh;
		r.mid = MID_W'(p.hl) + MID_W'(p.lh) + MID_W'(p.ll >> RCP_SPLIT);
		return r;
	endfunction

	function automatic logic [QUO_W-1:0] rcp_quotient(input pm_t m);
		logic [ACC_W-1:0] acc;
		acc = ACC_W'({m.hh, {RCP_SPLIT{1'b0}}}) + ACC_W'(m.mid);
		return acc[RCP_K-RCP_SPLIT +: QUO_W];
	endfunction

	function automatic logic signed [SUM_W-1:0] clamp_sym(
		input logic signed [SUM_W-1:0] x,
		input logic [UVAL_W-1:0] lim
	);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed(SUM_W'(lim));
		lo = -hi;
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	logic [MUL_W-1:0] xsq_s1;
	logic [MUL_W-1:0] ysq_s1;
	logic signed [DATA_W-1:0] v_s1;
	logic signed [DATA_W-1:0] w_s1;
	logic [PROD_W-1:0] lin_prod_s1;
	logic [PROD_W-1:0] ang_prod_s1;
	logic vld_s1;

	pp_t lin_pp_s2;
	pp_t ang_pp_s2;
	pm_t lin_pm_s2;
	pm_t ang_pm_s2;
	logic [QUO_W-1:0] lin_quo_s2;
	logic [QUO_W-1:0] ang_quo_s2;

	row1_t row1_s2 [SQ_W+1];
	logic [SQ_W:0] vld1_s2;

	logic [MUL_W-1:0] prod_lo_s3;
	logic dist_hi_s3;
	logic [UVAL_W-1:0] v_lo_s3;
	logic signed [DATA_W-1:0] v_hi_s3;
	logic signed [DATA_W-1:0] w_lo_s3;
	logic signed [DATA_W-1:0] w_hi_s3;
	logic vld_s3;

	row2_t row2_s4 [SQ_W+1];
	logic [SQ_W:0] vld2_s4;

	out_item_t result_s5;
	logic done_s5;

	logic [DATA_W-1:0] accel2;
	logic [SQ_W-1:0] dist_root;
	logic [2*DATA_W:0] sq_sum;
	logic signed [SUM_W-1:0] v_ext;
	logic signed [SUM_W-1:0] w_ext;
	logic signed [SUM_W-1:0] dv_ext;
	logic signed [SUM_W-1:0] dw_ext;
	logic signed [SUM_W-1:0] vl_c;
	logic signed [SUM_W-1:0] vh_c;
	logic signed [SUM_W-1:0] wl_c;
	logic signed [SUM_W-1:0] wh_c;
	logic [MUL_W:0] rad2_sum;
	logic [SQ_W-1:0] cap;
	logic capped;
	logic signed [DATA_W-1:0] hi_val;
	logic raise;

	always_comb begin
		accel2 = {cfg.max_linear_accel, 1'b0};
		sq_sum = {1'b0, xsq_s1} + {1'b0, ysq_s1};
		dist_root = row1_s2[SQ_W].sq.root;
		v_ext = SUM_W'($signed(row1_s2[SQ_W].v));
		w_ext = SUM_W'($signed(row1_s2[SQ_W].w));
		dv_ext = $signed(SUM_W'(row1_s2[SQ_W].lin_step));
		dw_ext = $signed(SUM_W'(row1_s2[SQ_W].ang_step));
		vl_c = clamp_sym(v_ext - dv_ext, cfg.max_linear_velocity);
		vh_c = clamp_sym(v_ext + dv_ext, cfg.max_linear_velocity);
		wl_c = clamp_sym(w_ext - dw_ext, cfg.max_angular_velocity);
		wh_c = clamp_sym(w_ext + dw_ext, cfg.max_angular_velocity);
		rad2_sum = {1'b0, prod_lo_s3}
			+ {1'b0, (dist_hi_s3 ? {accel2, {DATA_W{1'b0}}} : {MUL_W{1'b0}})};
		cap = row2_s4[SQ_W].sq.root;
		capped = !row2_s4[SQ_W].v_hi[DATA_W-1]
			&& ({2'b00, row2_s4[SQ_W].v_hi[UVAL_W-1:0]} > cap);
		hi_val = capped ? $signed({1'b0, cap[UVAL_W-1:0]}) : row2_s4[SQ_W].v_hi;
		raise = hi_val < $signed({1'b0, row2_s4[SQ_W].v_lo});
	end

	always_ff @(posedge clk) begin
		xsq_s1 <= MUL_W'(in_item.ux) * MUL_W'(in_item.ux);
		ysq_s1 <= MUL_W'(in_item.uy) * MUL_W'(in_item.uy);
		v_s1 <= in_item.v;
		w_s1 <= in_item.w;
		lin_prod_s1 <= in_item.lin_prod;
		ang_prod_s1 <= in_item.ang_prod;

		lin_pp_s2 <= rcp_products(lin_prod_s1);
		ang_pp_s2 <= rcp_products(ang_prod_s1);
		lin_pm_s2 <= rcp_fold(lin_pp_s2);
		ang_pm_s2 <= rcp_fold(ang_pp_s2);
		lin_quo_s2 <= rcp_quotient(lin_pm_s2);
		ang_quo_s2 <= rcp_quotient(ang_pm_s2);

		row1_s2[0].rad <= RAD_W'(sq_sum);
		row1_s2[0].sq <= '0;
		row1_s2[0].v <= v_s1;
		row1_s2[0].w <= w_s1;
		row1_s2[0].lin_step <= '0;
		row1_s2[0].ang_step <= '0;
		for (int k = 1; k <= SQ_W; k++) begin
			row1_s2[k].rad <= row1_s2[k-1].rad << 2;
			row1_s2[k].sq <= sqrt_step(row1_s2[k-1].sq, row1_s2[k-1].rad[RAD_W-1 -: 2]);
			row1_s2[k].v <= row1_s2[k-1].v;
			row1_s2[k].w <= row1_s2[k-1].w;
			if (k == DIV_LAT) begin
				row1_s2[k].lin_step <= lin_quo_s2;
				row1_s2[k].ang_step <= ang_quo_s2;
			end else begin
				row1_s2[k].lin_step <= row1_s2[k-1].lin_step;
				row1_s2[k].ang_step <= row1_s2[k-1].ang_step;
			end
		end

		prod_lo_s3 <= MUL_W'(accel2) * MUL_W'(dist_root[DATA_W-1:0]);
		dist_hi_s3 <= dist_root[SQ_W-1];
		v_lo_s3 <= vl_c[SUM_W-1] ? '0 : vl_c[UVAL_W-1:0];
		v_hi_s3 <= vh_c[DATA_W-1:0];
		w_lo_s3 <= wl_c[DATA_W-1:0];
		w_hi_s3 <= wh_c[DATA_W-1:0];

		row2_s4[0].rad <= RAD_W'(rad2_sum);
		row2_s4[0].sq <= '0;
		row2_s4[0].v_lo <= v_lo_s3;
		row2_s4[0].v_hi <= v_hi_s3;
		row2_s4[0].w_lo <= w_lo_s3;
		row2_s4[0].w_hi <= w_hi_s3;
		for (int k = 1; k <= SQ_W; k++) begin
			row2_s4[k].rad <= row2_s4[k-1].rad << 2;
			row2_s4[k].sq <= sqrt_step(row2_s4[k-1].sq, row2_s4[k-1].rad[RAD_W-1 -: 2]);
			row2_s4[k].v_lo <= row2_s4[k-1].v_lo;
			row2_s4[k].v_hi <= row2_s4[k-1].v_hi;
			row2_s4[k].w_lo <= row2_s4[k-1].w_lo;
			row2_s4[k].w_hi <= row2_s4[k-1].w_hi;
		end

		result_s5.lin_low <= row2_s4[SQ_W].v_lo;
		result_s5.lin_high <= raise ? row2_s4[SQ_W].v_lo : hi_val[UVAL_W-1:0];
		result_s5.ang_low <= row2_s4[SQ_W].w_lo;
		result_s5.ang_high <= row2_s4[SQ_W].w_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld1_s2 <= '0;
			vld_s3 <= 1'b0;
			vld2_s4 <= '0;
			done_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld1_s2 <= {vld1_s2[SQ_W-1:0], vld_s1};
			vld_s3 <= vld1_s2[SQ_W];
			vld2_s4 <= {vld2_s4[SQ_W-1:0], vld_s3};
			done_s5 <= vld2_s4[SQ_W];
		end
	end

	assign done = done_s5;
	assign result = result_s5;

endmodule

@@ rtl/core/dynamic_window_bounds.sv @@
// Dynamic window bounds: configuration registers, front end, queue and back end.
// Accepts one sample per cycle while busy is low.
// The latency is set by the two 33-stage square root pipelines in the back end.
// The receiver cannot stall; busy rises only when the entry queue is full.
// Reset restores the configuration registers and empties the queue and pipeline.
module dynamic_window_bounds
	import dwb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_addr,
	input logic [DATA_W-1:0] cfg_wdata,
	output logic done,
	output out_item_t result
);

	cfg_t cfg_q;
	q_item_t entry;
	q_item_t head;
	logic q_empty;
	logic q_full;
	logic accept;

	assign accept = start && !q_full;
	assign busy = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_PERIOD: cfg_q.period_ms <= cfg_wdata[PERIOD_W-1:0];
				CFG_MAX_LIN_VEL: cfg_q.max_linear_velocity <= cfg_wdata[UVAL_W-1:0];
				CFG_MAX_ANG_VEL: cfg_q.max_angular_velocity <= cfg_wdata[UVAL_W-1:0];
				CFG_MAX_LIN_ACCEL: cfg_q.max_linear_accel <= cfg_wdata[UVAL_W-1:0];
				CFG_MAX_ANG_ACCEL: cfg_q.max_angular_accel <= cfg_wdata[UVAL_W-1:0];
				CFG_GOAL_X: cfg_q.goal_x <= $signed(cfg_wdata);
				CFG_GOAL_Y: cfg_q.goal_y <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	dwb_front u_front (
		.item(item),
		.cfg(cfg_q),
		.entry(entry)
	);

	dwb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.wdata(entry),
		.pop(!q_empty),
		.rdata(head),
		.empty(q_empty),
		.full(q_full)
	);

	dwb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!q_empty),
		.in_item(head),
		.cfg(cfg_q),
		.done(done),
		.result(result)
	);

	a_never_full: assert property (@(posedge clk) disable iff (!arst_n) !q_full)
		else $error("entry queue filled although the back end drains every cycle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LATENCY done)
		else $error("accepted sample did not produce a result at the expected latency");

	a_lin_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.lin_high >= result.lin_low))
		else $error("upper forward bound below lower forward bound");

	a_lin_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.lin_low <= cfg_q.max_linear_velocity))
		else $error("lower forward bound exceeds the velocity limit");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for dynamic_window_bounds: directed table, then random phases.
// Predicts each velocity window in the testbench or takes it from the directed table,
// and checks every done beat against it. Depends on dwb_pkg and the dynamic_window_bounds RTL.
module tb_top;
	import dwb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 96;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] addr;
		logic [DATA_W-1:0] data;
		in_item_t sample;
		out_item_t known;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [DATA_W-1:0] cfg_wdata;
	logic done;
	out_item_t result;

	cfg_t regs_model;
	out_item_t window_due[$];
	out_item_t due;
	dir_row_t dir_tab[$];
	int errors = 0;
	int windows_checked = 0;
	int samples_sent = 0;
	int writes_done = 0;
	int cycle_count = 0;

	dynamic_window_bounds u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d windows outstanding", cycle_count,
				window_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint clamp_to(input longint v, input longint lim);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic logic [33:0] floor_sqrt(input logic [67:0] x);
		logic [33:0] root;
		logic [33:0] trial;
		logic [67:0] sq;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (34'd1 << b);
			sq = trial;
			sq = sq * sq;
			if (sq <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic out_item_t predict_window(input in_item_t s, input cfg_t c);
		longint accel_lin, accel_ang, period, vlim, wlim, lin_step, ang_step;
		longint v, w, dx, dy, gx, gy, v_lo, v_hi, w_lo, w_hi, cap;
		logic [32:0] ux, uy;
		logic [67:0] dist_sq, brake_sq;
		logic [33:0] dist_root;
		out_item_t r;
		accel_lin = c.max_linear_accel;
		accel_ang = c.max_angular_accel;
		period = c.period_ms;
		vlim = c.max_linear_velocity;
		wlim = c.max_angular_velocity;
		gx = c.goal_x;
		gy = c.goal_y;
		v = s.forward_velocity;
		w = s.turn_rate;
		dx = s.pos_x;
		dy = s.pos_y;
		lin_step = accel_lin * period / 1000;
		ang_step = accel_ang * period / 1000;
		v_lo = clamp_to(v - lin_step, vlim);
		v_hi = clamp_to(v + lin_step, vlim);
		w_lo = clamp_to(w - ang_step, wlim);
		w_hi = clamp_to(w + ang_step, wlim);
		if (v_lo < 0)
			v_lo = 0;
		dx = dx - gx;
		dy = dy - gy;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		ux = dx[32:0];
		uy = dy[32:0];
		dist_sq = ux;
		dist_sq = dist_sq * ux;
		brake_sq = uy;
		brake_sq = brake_sq * uy;
		dist_sq = dist_sq + brake_sq;
		dist_root = floor_sqrt(dist_sq);
		brake_sq = 2 * accel_lin;
		brake_sq = brake_sq * dist_root;
		cap = floor_sqrt(brake_sq);
		if (v_hi >= 0 && v_hi > cap)
			v_hi = cap;
		if (v_hi < v_lo)
			v_hi = v_lo;
		r.lin_low = v_lo[UVAL_W-1:0];
		r.lin_high = v_hi[UVAL_W-1:0];
		r.ang_low = w_lo[DATA_W-1:0];
		r.ang_high = w_hi[DATA_W-1:0];
		return r;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (window_due.size() == 0) begin
				flag_error($sformatf("unexpected window lin %0d..%0d ang %0d..%0d",
					result.lin_low, result.lin_high, $signed(result.ang_low),
					$signed(result.ang_high)));
			end else begin
				due = window_due.pop_front();
				windows_checked++;
				if (result.lin_low !== due.lin_low || result.lin_high !== due.lin_high ||
						result.ang_low !== due.ang_low || result.ang_high !== due.ang_high) begin
					flag_error($sformatf(
						"window %0d: expected lin %0d..%0d ang %0d..%0d, got lin %0d..%0d ang %0d..%0d",
						windows_checked, due.lin_low, due.lin_high, $signed(due.ang_low),
						$signed(due.ang_high), result.lin_low, result.lin_high,
						$signed(result.ang_low), $signed(result.ang_high)));
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_sample(input in_item_t s, input bit use_known, input out_item_t known);
		start <= 1'b1;
		item <= s;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		window_due.push_back(use_known ? known : predict_window(s, regs_model));
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (window_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_PERIOD: regs_model.period_ms = data[PERIOD_W-1:0];
			CFG_MAX_LIN_VEL: regs_model.max_linear_velocity = data[UVAL_W-1:0];
			CFG_MAX_ANG_VEL: regs_model.max_angular_velocity = data[UVAL_W-1:0];
			CFG_MAX_LIN_ACCEL: regs_model.max_linear_accel = data[UVAL_W-1:0];
			CFG_MAX_ANG_ACCEL: regs_model.max_angular_accel = data[UVAL_W-1:0];
			CFG_GOAL_X: regs_model.goal_x = data;
			CFG_GOAL_Y: regs_model.goal_y = data;
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		dir_row_t row;
		row.kind = ROW_WRITE;
		row.addr = idx;
		row.data = data;
		row.sample = '0;
		row.known = '0;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_sample(input in_item_t s);
		dir_row_t row;
		row.kind = ROW_SAMPLE;
		row.addr = '0;
		row.data = '0;
		row.sample = s;
		row.known = '0;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_known(input in_item_t s, input out_item_t e);
		dir_row_t row;
		row.kind = ROW_KNOWN;
		row.addr = '0;
		row.data = '0;
		row.sample = s;
		row.known = e;
		dir_tab.push_back(row);
	endfunction

	function automatic logic [DATA_W-1:0] pick_reg_value(input int idx);
		logic [DATA_W-1:0] d;
		d = $urandom;
		if (idx == CFG_PERIOD) begin
			case ($urandom_range(0, 7))
				0: d[PERIOD_W-1:0] = 10'd0;
				1: d[PERIOD_W-1:0] = 10'd1;
				2: d[PERIOD_W-1:0] = 10'd1000;
				3: d[PERIOD_W-1:0] = 10'd1023;
				default: d[PERIOD_W-1:0] = $urandom_range(1, 1000);
			endcase
		end else if (idx == CFG_GOAL_X || idx == CFG_GOAL_Y) begin
			case ($urandom_range(0, 7))
				0: d = 32'h80000000;
				1: d = 32'h7FFFFFFF;
				2, 3, 4: d = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
				default: ;
			endcase
		end else begin
			case ($urandom_range(0, 7))
				0: d[UVAL_W-1:0] = '0;
				1: d[UVAL_W-1:0] = '1;
				2, 3, 4: d[UVAL_W-1:0] = $urandom_range(0, 32'h000FFFFF);
				5: d[UVAL_W-1:0] = $urandom_range(0, 32'h03FFFFFF);
				default: ;
			endcase
		end
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] pick_velocity(input longint lim);
		longint span, mag;
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			1, 2, 3, 4: begin
				span = 2 * lim + 4096;
				if (span > 64'h7FFFFFFF)
					span = 64'h7FFFFFFF;
				mag = $urandom_range(0, span);
				if ($urandom_range(0, 1))
					mag = -mag;
				return mag[DATA_W-1:0];
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_position(input logic signed [DATA_W-1:0] goal);
		longint g, off;
		g = goal;
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			1: begin
				off = $urandom_range(0, 32);
				off = off - 16;
			end
			2, 3, 4: begin
				off = $urandom_range(0, 524288);
				off = off - 262144;
			end
			default: return $urandom;
		endcase
		g = g + off;
		return g[DATA_W-1:0];
	endfunction

	function automatic in_item_t random_sample();
		in_item_t s;
		s.forward_velocity = pick_velocity(regs_model.max_linear_velocity);
		s.turn_rate = pick_velocity(regs_model.max_angular_velocity);
		s.pos_x = pick_position(regs_model.goal_x);
		s.pos_y = pick_position(regs_model.goal_y);
		return s;
	endfunction

	initial begin
		int burst_left, gap;
		bit steady;
		dir_row_t row;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		regs_model = CFG_RESET;

		add_known('{32'sd0, 32'sd0, 32'sd131072, 32'sd65536},
			'{31'd0, 31'd0, -32'sd6553, 32'sd6553});
		add_known('{32'h7FFFFFFF, 32'h80000000, 32'sd131072, 32'sd65536},
			'{31'd32768, 31'd32768, -32'sd65536, -32'sd65536});
		add_known('{32'h80000000, 32'h7FFFFFFF, 32'sd131072, 32'sd65536},
			'{31'd0, 31'd0, 32'sd65536, 32'sd65536});
		add_sample('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
		add_sample('{32'h00001000, 32'hFFFFE000, 32'h7FFFFFFF, 32'h80000000});
		add_sample('{32'hFFFFF000, 32'h00000100, 32'h80000000, 32'h7FFFFFFF});
		add_sample('{32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'h00000000});
		add_write(CFG_PERIOD, 32'd0);
		add_known('{32'sd12345, -32'sd777, 32'sd131072, 32'sd65536},
			'{31'd12345, 31'd12345, -32'sd777, -32'sd777});
		add_sample('{32'sd12345, -32'sd777, 32'sd0, 32'sd0});
		add_write(CFG_PERIOD, 32'hFFFFFFFF);
		add_write(CFG_MAX_LIN_ACCEL, 32'h80000000);
		add_known('{32'sd32768, 32'sd0, 32'sd0, 32'sd0},
			'{31'd32768, 31'd32768, -32'sd65536, 32'sd65536});
		add_write(CFG_NONE, 32'hFFFFFFFF);
		add_sample('{32'h00004000, 32'h00004000, 32'h7FFFFFFF, 32'h7FFFFFFF});
		add_write(CFG_PERIOD, 32'd1000);
		add_write(CFG_MAX_LIN_VEL, 32'h7FFFFFFF);
		add_write(CFG_MAX_ANG_VEL, 32'h7FFFFFFF);
		add_write(CFG_MAX_LIN_ACCEL, 32'h7FFFFFFF);
		add_write(CFG_MAX_ANG_ACCEL, 32'h7FFFFFFF);
		add_write(CFG_GOAL_X, 32'h80000000);
		add_write(CFG_GOAL_Y, 32'h7FFFFFFF);
		add_sample('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000});
		add_known('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
			'{31'd0, 31'd0, 32'h80000001, 32'hFFFFFFFF});
		add_sample('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
		add_known('{32'h7FFFFFFF, 32'sd0, 32'h80000000, 32'h7FFFFFFF},
			'{31'd0, 31'd0, 32'h80000001, 32'h7FFFFFFF});
		add_write(CFG_MAX_LIN_VEL, 32'd0);
		add_write(CFG_MAX_ANG_VEL, 32'd0);
		add_write(CFG_PERIOD, 32'd1);
		add_known('{32'h12345678, 32'h9ABCDEF0, 32'h5555AAAA, 32'hAAAA5555},
			'{31'd0, 31'd0, 32'sd0, 32'sd0});

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < dir_tab.size(); i++) begin
			row = dir_tab[i];
			case (row.kind)
				ROW_WRITE: begin
					wait_drained();
					write_reg(row.addr, row.data);
				end
				ROW_SAMPLE: send_sample(row.sample, 1'b0, '0);
				default: send_sample(row.sample, 1'b1, row.known);
			endcase
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_drained();
			for (int r = CFG_PERIOD; r <= CFG_GOAL_Y; r++) begin
				if (phase == 0 || $urandom_range(0, 1))
					write_reg(r[CFG_IDX_W-1:0], pick_reg_value(r));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_NONE, $urandom);
			steady = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(1, 20);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_sample(random_sample(), 1'b0, '0);
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					if (!steady) begin
						gap = $urandom_range(1, 15);
						start <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
			end
		end

		wait_drained();
		repeat (PIPE_LATENCY + 8) @(negedge clk);
		if (window_due.size() != 0)
			flag_error($sformatf("%0d windows never arrived", window_due.size()));
		$display("Checked %0d windows from %0d samples across %0d register writes,",
			windows_checked, samples_sent, writes_done);
		$display("covering limit extremes, zero and oversized periods, goal reached, reverse.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
